>>> sv/rswm_pkg.sv
package rswm_pkg;

  // Window length in colours
  localparam int WINDOW_DEPTH = 16;

  // Derived widths
  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = 8 + PTR_W;
  localparam int CHAN_W = 8;
  localparam int WORD_W = 3 * CHAN_W;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // Sequencer state codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // Channel select codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

endpackage

>>> sv/rswm_ram.sv
module rswm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/rgb_sliding_window_mean_unit.sv
// Channel | Ports                                   | Handshake
// input   | in_red_in, in_green_in, in_blue_in      | in_valid / in_ready
// result  | out_red_mean, out_green_mean, out_blue_mean | out_valid / out_ready
//
// An item is accepted in S_IDLE, then passes through the sum update (S_UPD) and the
// shared restoring divider (S_LOAD, S_DIV per channel, one quotient bit a cycle) to S_OUT.
// in_ready is high only while idle, so a new item waits until the last one leaves S_OUT.
// Synchronous reset empties the window and clears the sums; the RAM is left as is.
// A stalled result holds the output register while the next item is worked on;
// that item's result waits until the register frees.
module rgb_sliding_window_mean_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rswm_pkg::chan_t in_red_in,
  input  rswm_pkg::chan_t in_green_in,
  input  rswm_pkg::chan_t in_blue_in,
  output logic           out_valid,
  input  logic           out_ready,
  output rswm_pkg::chan_t out_red_mean,
  output rswm_pkg::chan_t out_green_mean,
  output rswm_pkg::chan_t out_blue_mean
);
  import rswm_pkg::*;

  logic [2:0]  state_r, state_nxt;
  chan_t       red_r, red_nxt;
  chan_t       green_r, green_nxt;
  chan_t       blue_r, blue_nxt;
  sum_t        rsum_r, rsum_nxt;
  sum_t        gsum_r, gsum_nxt;
  sum_t        bsum_r, bsum_nxt;
  cnt_t        fill_r, fill_nxt;
  ptr_t        ptr_r, ptr_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [2:0]  step_r, step_nxt;
  cnt_t        rem_r, rem_nxt;
  chan_t       dlo_r, dlo_nxt;
  chan_t       quo_r, quo_nxt;
  chan_t       rq_r, rq_nxt;
  chan_t       gq_r, gq_nxt;
  chan_t       bq_r, bq_nxt;
  logic        ovalid_r, ovalid_nxt;
  chan_t       ored_r, ored_nxt;
  chan_t       ogreen_r, ogreen_nxt;
  chan_t       oblue_r, oblue_nxt;

  logic              full;
  logic [PTR_W:0]    slot_sum;
  ptr_t              slot;
  ptr_t              ptr_inc;
  logic              ram_we;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] old_word;
  sum_t              sum_sel;
  logic [CNT_W:0]    trial;
  logic              take;
  logic              accept;

  assign full     = (fill_r == cnt_t'(WINDOW_DEPTH));
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Write slot: oldest when full, else oldest + fill wrapped once
  assign slot_sum = {1'b0, ptr_r} + (PTR_W+1)'(fill_r);
  always_comb begin
    if (full) begin
      slot = ptr_r;
    end else if (slot_sum >= (PTR_W+1)'(WINDOW_DEPTH)) begin
      slot = PTR_W'(slot_sum - (PTR_W+1)'(WINDOW_DEPTH));
    end else begin
      slot = slot_sum[PTR_W-1:0];
    end
  end

  assign ptr_inc = (ptr_r == ptr_t'(WINDOW_DEPTH - 1)) ? '0 : ptr_r + ptr_t'(1);
  assign ram_we  = (state_r == S_UPD);

  // History of colours, packed {red, green, blue}
  rswm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot),
    .wdata({red_r, green_r, blue_r}),
    .raddr(ptr_r),
    .rdata(ram_rdata)
  );

  // Oldest colour counts only once the window is full
  assign old_word = full ? ram_rdata : '0;

  // Divider operand select
  always_comb begin
    case (ch_r)
      CH_RED:   sum_sel = rsum_r;
      CH_GREEN: sum_sel = gsum_r;
      default:  sum_sel = bsum_r;
    endcase
  end

  // One restoring step: quotient never exceeds 8 bits, remainder below fill
  assign trial = {rem_r, dlo_r[CHAN_W-1]};
  assign take  = (trial >= {1'b0, fill_r});

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    blue_nxt   = blue_r;
    rsum_nxt   = rsum_r;
    gsum_nxt   = gsum_r;
    bsum_nxt   = bsum_r;
    fill_nxt   = fill_r;
    ptr_nxt    = ptr_r;
    ch_nxt     = ch_r;
    step_nxt   = step_r;
    rem_nxt    = rem_r;
    dlo_nxt    = dlo_r;
    quo_nxt    = quo_r;
    rq_nxt     = rq_r;
    gq_nxt     = gq_r;
    bq_nxt     = bq_r;
    ovalid_nxt = ovalid_r;
    ored_nxt   = ored_r;
    ogreen_nxt = ogreen_r;
    oblue_nxt  = oblue_r;

    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          red_nxt   = in_red_in;
          green_nxt = in_green_in;
          blue_nxt  = in_blue_in;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        rsum_nxt = rsum_r + SUM_W'(red_r)   - SUM_W'(old_word[3*CHAN_W-1:2*CHAN_W]);
        gsum_nxt = gsum_r + SUM_W'(green_r) - SUM_W'(old_word[2*CHAN_W-1:CHAN_W]);
        bsum_nxt = bsum_r + SUM_W'(blue_r)  - SUM_W'(old_word[CHAN_W-1:0]);
        if (full) begin
          ptr_nxt = ptr_inc;
        end else begin
          fill_nxt = fill_r + cnt_t'(1);
        end
        ch_nxt    = CH_RED;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        rem_nxt   = CNT_W'(sum_sel[SUM_W-1:CHAN_W]);
        dlo_nxt   = sum_sel[CHAN_W-1:0];
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = take ? CNT_W'(trial - {1'b0, fill_r}) : trial[CNT_W-1:0];
        dlo_nxt  = {dlo_r[CHAN_W-2:0], 1'b0};
        quo_nxt  = {quo_r[CHAN_W-2:0], take};
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          case (ch_r)
            CH_RED: begin
              rq_nxt    = {quo_r[CHAN_W-2:0], take};
              ch_nxt    = CH_GREEN;
              state_nxt = S_LOAD;
            end
            CH_GREEN: begin
              gq_nxt    = {quo_r[CHAN_W-2:0], take};
              ch_nxt    = CH_BLUE;
              state_nxt = S_LOAD;
            end
            default: begin
              bq_nxt    = {quo_r[CHAN_W-2:0], take};
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_OUT: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          ored_nxt   = rq_r;
          ogreen_nxt = gq_r;
          oblue_nxt  = bq_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rsum_r   <= '0;
      gsum_r   <= '0;
      bsum_r   <= '0;
      fill_r   <= '0;
      ptr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rsum_r   <= rsum_nxt;
      gsum_r   <= gsum_nxt;
      bsum_r   <= bsum_nxt;
      fill_r   <= fill_nxt;
      ptr_r    <= ptr_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload and divider working registers
  always_ff @(posedge clk) begin
    red_r    <= red_nxt;
    green_r  <= green_nxt;
    blue_r   <= blue_nxt;
    ch_r     <= ch_nxt;
    step_r   <= step_nxt;
    rem_r    <= rem_nxt;
    dlo_r    <= dlo_nxt;
    quo_r    <= quo_nxt;
    rq_r     <= rq_nxt;
    gq_r     <= gq_nxt;
    bq_r     <= bq_nxt;
    ored_r   <= ored_nxt;
    ogreen_r <= ogreen_nxt;
    oblue_r  <= oblue_nxt;
  end

  assign out_valid      = ovalid_r;
  assign out_red_mean   = ored_r;
  assign out_green_mean = ogreen_r;
  assign out_blue_mean  = oblue_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cnt_t'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (fill_r != '0))
    else $error("divide step with empty window");

  a_ptr_still: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r < cnt_t'(WINDOW_DEPTH)) |-> (ptr_r == '0))
    else $error("oldest pointer moved before window filled");

  a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_UPD))
    else $error("accepted item not followed by sum update");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ptr_r} < (PTR_W+1)'(WINDOW_DEPTH))
    else $error("oldest pointer out of range");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rswm_pkg::*;

  localparam int RANDOM_ITEMS = 1125;
  localparam int SETTLE_CYCLES = 40;        // idle time after the last mean, before the final check

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } colour_t;

  // Receiver stall behaviour
  typedef enum logic [1:0] {RDY_FREE, RDY_COIN, RDY_SPARSE} ready_mode_t;

  // Flavour of the colours within one random burst
  typedef enum logic [1:0] {HUE_RANDOM, HUE_FULL, HUE_ZERO, HUE_EDGE} hue_kind_t;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  chan_t in_red_in;
  chan_t in_green_in;
  chan_t in_blue_in;
  logic  out_valid;
  logic  out_ready;
  chan_t out_red_mean;
  chan_t out_green_mean;
  chan_t out_blue_mean;

  // Mirror of the filter's window
  colour_t history [WINDOW_DEPTH];
  sum_t    red_total;
  sum_t    green_total;
  sum_t    blue_total;
  cnt_t    held;
  ptr_t    oldest;

  colour_t     expected_means [$];
  colour_t     want_mean;
  int          mismatch_count = 0;
  ready_mode_t ready_mode;
  int          phase_left;

  rgb_sliding_window_mean_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red_mean   (out_red_mean),
    .out_green_mean (out_green_mean),
    .out_blue_mean  (out_blue_mean)
  );

  always #2 clk = ~clk;

  // Push one colour into the window and return the truncated channel means
  function automatic colour_t advance_window(input colour_t c);
    colour_t old;
    colour_t mean;
    int      slot;
    red_total   += c.red;
    green_total += c.green;
    blue_total  += c.blue;
    if (held < WINDOW_DEPTH) begin
      slot = (int'(oldest) + int'(held)) % WINDOW_DEPTH;
      history[slot] = c;
      held++;
    end else begin
      // window full: drop the oldest colour
      old = history[oldest];
      red_total   -= old.red;
      green_total -= old.green;
      blue_total  -= old.blue;
      history[oldest] = c;
      oldest = ptr_t'((int'(oldest) + 1) % WINDOW_DEPTH);
    end
    mean.red   = chan_t'(red_total / held);
    mean.green = chan_t'(green_total / held);
    mean.blue  = chan_t'(blue_total / held);
    return mean;
  endfunction

  function automatic chan_t edge_level();
    case ($urandom_range(0, 6))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      3: return 8'hFE;
      4: return 8'h80;
      5: return 8'h7F;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic colour_t make_colour(input hue_kind_t kind);
    colour_t c;
    case (kind)
      HUE_FULL: c = '{8'hFF, 8'hFF, 8'hFF};
      HUE_ZERO: c = '{8'h00, 8'h00, 8'h00};
      HUE_EDGE: c = '{edge_level(), edge_level(), edge_level()};
      default:  c = '{chan_t'($urandom_range(0, 255)), chan_t'($urandom_range(0, 255)),
                      chan_t'($urandom_range(0, 255))};
    endcase
    return c;
  endfunction

  // Offer one colour and wait for the filter to take it
  task automatic send_colour(input colour_t c);
    colour_t want;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_red_in   <= c.red;
    in_green_in <= c.green;
    in_blue_in  <= c.blue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = advance_window(c);
    expected_means = {expected_means, want};
  endtask

  // Drop valid for a pause whose length is set by n; payload is scrambled while idle
  task automatic pause_input(input int n);
    @(negedge clk);
    in_valid    <= 1'b0;
    in_red_in   <= chan_t'($urandom_range(0, 255));
    in_green_in <= chan_t'($urandom_range(0, 255));
    in_blue_in  <= chan_t'($urandom_range(0, 255));
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_all_means;
    while (expected_means.size() != 0) @(posedge clk);
  endtask

  task automatic check_channel(input string name, input chan_t want, input chan_t got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mean mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Extreme and bit-pattern colours while the window is filling
  task automatic test_extremes;
    send_colour('{8'h00, 8'h00, 8'h00});
    send_colour('{8'hFF, 8'hFF, 8'hFF});
    send_colour('{8'hFF, 8'h00, 8'h00});
    send_colour('{8'h00, 8'hFF, 8'h00});
    send_colour('{8'h00, 8'h00, 8'hFF});
    send_colour('{8'hAA, 8'h55, 8'hAA});
    send_colour('{8'h55, 8'hAA, 8'h55});
    send_colour('{8'h01, 8'hFE, 8'h80});
  endtask

  // Fill the window to the brim, then push past it so the oldest colours drop out
  task automatic test_window_wrap;
    repeat (8) send_colour('{8'hFF, 8'hFF, 8'hFF});
    repeat (9) begin
      send_colour('{8'h00, 8'h07, 8'hFF});
      pause_input($urandom_range(1, 3));
    end
  endtask

  // Hold the sender off until every mean has come back
  task automatic test_drain_pause;
    pause_input(1);
    wait_all_means();
    repeat ($urandom_range(2, 20)) @(negedge clk);
  endtask

  // Bursts of random colours with random gaps, draining once half way
  task automatic test_random;
    int        sent;
    int        burst_len;
    bit        drained;
    hue_kind_t kind;
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0:       kind = HUE_FULL;
        1:       kind = HUE_ZERO;
        2, 3:    kind = HUE_EDGE;
        default: kind = HUE_RANDOM;
      endcase
      repeat (burst_len) begin
        send_colour(make_colour(kind));
        sent++;
      end
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        test_drain_pause();
        drained = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        pause_input($urandom_range(1, 35));
      end
    end
  endtask

  // Receiver stall pattern: free, coin toss, or mostly stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b1;
      phase_left <= 0;
      ready_mode <= RDY_FREE;
    end else if (phase_left == 0) begin
      case ($urandom_range(0, 2))
        0:       ready_mode <= RDY_FREE;
        1:       ready_mode <= RDY_COIN;
        default: ready_mode <= RDY_SPARSE;
      endcase
      phase_left <= $urandom_range(20, 300);
      out_ready  <= 1'b1;
    end else begin
      phase_left <= phase_left - 1;
      case (ready_mode)
        RDY_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
        RDY_SPARSE: out_ready <= ((phase_left % 32) < 4);
        default:    out_ready <= 1'b1;
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_means.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected mean, expected none, actual %0d/%0d/%0d", $time,
                 out_red_mean, out_green_mean, out_blue_mean);
      end else begin
        want_mean = expected_means.pop_front();
        check_channel("red", want_mean.red, out_red_mean);
        check_channel("green", want_mean.green, out_green_mean);
        check_channel("blue", want_mean.blue, out_blue_mean);
      end
    end
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("rgb_sliding_window_mean_unit test failed");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_red_in      = '0;
    in_green_in    = '0;
    in_blue_in     = '0;
    red_total      = '0;
    green_total    = '0;
    blue_total     = '0;
    held           = '0;
    oldest         = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) history[i] = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_window_wrap();
    test_drain_pause();
    test_random();

    pause_input(1);
    wait_all_means();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_means.size() == 0) begin
      $display("rgb_sliding_window_mean_unit test passed");
    end else begin
      $display("rgb_sliding_window_mean_unit test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/rswm_pkg.sv
sv/rswm_ram.sv
sv/rgb_sliding_window_mean_unit.sv
tb/sv/tb_top.sv
